### rtl/tlbpt_pkg.sv
`default_nettype none

package tlbpt_pkg;

    // Fixed field widths of the request and result streams.
    localparam int ADDR_W    = 16;
    localparam int COUNT_W   = 32;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 88;

    // One translation result, physical address in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] fault_count;
        logic [COUNT_W-1:0] hit_count;
        logic               page_fault;
        logic               tlb_hit;
        logic [ADDR_W-1:0]  phys_addr;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_PAD_W  = M_TDATA_W - RESULT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

`default_nettype wire

### rtl/tlb_page_table_translator.sv
// The TLB compare and page-table read are registered at the accept edge; the update,
// the page-table write-back and the result register follow in the update cycle.
// The input takes no new address until the update of the last one is done;
// a full output register stalls the update and with it the input.
// Reset clears the TLB valid bits, the page-mapped bits, the fill pointer, the free
// frame counter and both counts; the page-table memory itself is not cleared.
`default_nettype none

module tlb_page_table_translator #(
    parameter int TLB_DEPTH   = 16,
    parameter int PAGE_BITS   = 8,
    parameter int OFFSET_BITS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Fields from bit 0: virt_addr[15:0].
    input  wire logic [tlbpt_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: phys_addr[15:0], tlb_hit, page_fault,
    // hit_count[31:0], fault_count[31:0], zero padding.
    output logic [tlbpt_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);
    import tlbpt_pkg::*;

    localparam int NUM_PAGES = 1 << PAGE_BITS;
    localparam int PTR_W     = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int FREE_W    = PAGE_BITS + 1;
    localparam int EXT_W     = ADDR_W + PAGE_BITS + OFFSET_BITS;
    localparam int PA_EXT_W  = ADDR_W + PAGE_BITS + OFFSET_BITS;

    // Address split of the incoming request.
    logic [EXT_W-1:0]       in_addr_ext;
    logic [PAGE_BITS-1:0]   in_page;
    logic [OFFSET_BITS-1:0] in_offset;
    logic                   in_accept;

    assign in_addr_ext = {{(PAGE_BITS + OFFSET_BITS){1'b0}}, s_tdata[ADDR_W-1:0]};
    assign in_page     = in_addr_ext[OFFSET_BITS +: PAGE_BITS];
    assign in_offset   = in_addr_ext[OFFSET_BITS-1:0];
    assign in_accept   = s_tvalid && s_tready;

    // TLB storage and control state.
    logic [PAGE_BITS-1:0] tlb_tag_reg   [TLB_DEPTH];
    logic [PAGE_BITS-1:0] tlb_frame_reg [TLB_DEPTH];
    logic [TLB_DEPTH-1:0] tlb_valid_reg;
    logic [PTR_W-1:0]     fill_ptr_reg;
    logic [PTR_W-1:0]     fill_ptr_next;
    logic [NUM_PAGES-1:0] mapped_reg;
    logic [FREE_W-1:0]    alloc_frame_reg;
    logic [COUNT_W-1:0]   hits_reg;
    logic [COUNT_W-1:0]   faults_reg;

    // Request held between the lookup and the update cycle.
    logic                   busy_reg;
    logic [PAGE_BITS-1:0]   page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   hit_reg;
    logic [PAGE_BITS-1:0]   hit_frame_reg;
    logic                   mapped_hit_reg;

    // Page-table memory.
    logic [PAGE_BITS-1:0] pt_mem [NUM_PAGES];
    logic [PAGE_BITS-1:0] pt_rdata_reg;
    logic                 pt_we;

    // Output register.
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;

    logic                 done;
    logic                 fault;
    logic [PAGE_BITS-1:0] frame;
    logic [PA_EXT_W-1:0]  pa_ext;
    logic                 match_any;
    logic [PAGE_BITS-1:0] match_frame;

    // Fully associative compare; the lowest-numbered valid entry wins.
    always_comb
    begin
        match_any   = 1'b0;
        match_frame = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && (tlb_tag_reg[i] == in_page))
            begin
                match_any   = 1'b1;
                match_frame = tlb_frame_reg[i];
            end
        end
    end

    assign s_tready = !busy_reg;
    assign done     = busy_reg && (!out_valid_reg || m_tready);

    // Frame selection: TLB hit, existing mapping, or a newly allocated frame.
    always_comb
    begin
        fault = 1'b0;
        if (hit_reg)
        begin
            frame = hit_frame_reg;
        end
        else if (mapped_hit_reg)
        begin
            frame = pt_rdata_reg;
        end
        else
        begin
            fault = 1'b1;
            frame = alloc_frame_reg[PAGE_BITS-1:0];
        end
    end

    assign pt_we  = done && fault;
    assign pa_ext = {{ADDR_W{1'b0}}, frame, offset_reg};

    always_comb
    begin
        result.phys_addr   = pa_ext[ADDR_W-1:0];
        result.tlb_hit     = hit_reg;
        result.page_fault  = fault;
        result.hit_count   = (hit_reg && (hits_reg != COUNT_MAX))
                             ? hits_reg + 1'b1 : hits_reg;
        result.fault_count = (fault && (faults_reg != COUNT_MAX))
                             ? faults_reg + 1'b1 : faults_reg;
    end

    assign fill_ptr_next = (fill_ptr_reg == PTR_W'(TLB_DEPTH - 1))
                           ? '0 : fill_ptr_reg + 1'b1;

    // Page-table memory: read on accept, written back on a fault.
    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[page_reg] <= alloc_frame_reg[PAGE_BITS-1:0];
        end
        if (in_accept)
        begin
            pt_rdata_reg <= pt_mem[in_page];
        end
    end

    // Lookup-stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            page_reg       <= in_page;
            offset_reg     <= in_offset;
            hit_reg        <= match_any;
            hit_frame_reg  <= match_frame;
            mapped_hit_reg <= mapped_reg[in_page];
        end
    end

    // TLB fill at the FIFO pointer after a miss.
    always_ff @(posedge clk)
    begin
        if (done && !hit_reg)
        begin
            tlb_tag_reg[fill_ptr_reg]   <= page_reg;
            tlb_frame_reg[fill_ptr_reg] <= frame;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= result;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            tlb_valid_reg   <= '0;
            fill_ptr_reg    <= '0;
            mapped_reg      <= '0;
            alloc_frame_reg <= '0;
            hits_reg        <= '0;
            faults_reg      <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end

            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (done)
            begin
                hits_reg   <= result.hit_count;
                faults_reg <= result.fault_count;
                if (!hit_reg)
                begin
                    tlb_valid_reg[fill_ptr_reg] <= 1'b1;
                    fill_ptr_reg                <= fill_ptr_next;
                end
                if (fault)
                begin
                    mapped_reg[page_reg] <= 1'b1;
                    if (alloc_frame_reg < FREE_W'(NUM_PAGES))
                    begin
                        alloc_frame_reg <= alloc_frame_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_reg};

    // The free frame counter never passes the number of pages.
    assert property (@(posedge clk) disable iff (!rst_n)
        alloc_frame_reg <= FREE_W'(NUM_PAGES))
        else $error("free frame counter beyond page count");

    // A delivered result never reports both a TLB hit and a page fault.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[ADDR_W] && m_tdata[ADDR_W + 1]))
        else $error("hit and fault reported together");

    // After a miss completes, its page is mapped in the page table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit_reg) |=> mapped_reg[$past(page_reg)])
        else $error("missed page left unmapped");

    // A TLB hit leaves the FIFO fill pointer where it was.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit_reg) |=> $stable(fill_ptr_reg))
        else $error("fill pointer moved on a hit");

endmodule

`default_nettype wire
